// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the clipmap mesh element generator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled in reset
`define CMEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define CMEG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/cmeg_pkg.sv -----
// Package for the clipmap mesh element generator: mesh codes, job and result
// types, and the one-bit-per-stage divider step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmeg_pkg;

  localparam int NUM_W     = 17;
  localparam int DVS_W     = 10;
  localparam int DIV_STAGES = NUM_W;
  localparam int T_RESET   = 32;

  localparam logic [2:0] MESH_TILE   = 3'd0;
  localparam logic [2:0] MESH_FILLER = 3'd1;
  localparam logic [2:0] MESH_TRIM   = 3'd2;
  localparam logic [2:0] MESH_CROSS  = 3'd3;
  localparam logic [2:0] MESH_SEAM   = 3'd4;

  typedef struct packed {
    logic              ok;
    logic [2:0]        mode;
    logic              tri_sel;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
  } cmeg_job_t;

  typedef struct packed {
    cmeg_job_t         job;
    logic [DVS_W-1:0]  rem;
    logic [NUM_W-1:0]  quo;
  } cmeg_div_t;

  typedef struct packed {
    logic               ok;
    logic signed [11:0] x;
    logic signed [11:0] z;
    logic [15:0]        ca;
    logic [15:0]        cb;
    logic [15:0]        cc;
  } cmeg_res_t;

  function automatic cmeg_div_t cmeg_div_step(cmeg_div_t d);
    cmeg_div_t      o;
    logic [DVS_W:0] tmp;
    o   = d;
    tmp = {d.rem, d.quo[NUM_W-1]};
    if (tmp >= {1'b0, d.job.dvs}) begin
      o.rem = DVS_W'(tmp - {1'b0, d.job.dvs});
      o.quo = {d.quo[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = tmp[DVS_W-1:0];
      o.quo = {d.quo[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cmeg_front.sv -----
// Front end: accepts transactions, checks the element range, sets up the
// division and queues the job. Depends on cmeg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cmeg_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [7:0]            tile_res,
  input  wire                  push,
  output logic                 full,
  input  wire [2:0]            in_mode,
  input  wire                  in_want_triangle,
  input  wire [16:0]           in_element_number,
  output logic                 q_valid,
  input  wire                  q_pop,
  output cmeg_pkg::cmeg_job_t  q_job
);
  import cmeg_pkg::*;

  logic [8:0]  p;
  logic [9:0]  c;
  logic [17:0] lim;
  logic [17:0] nn;
  cmeg_job_t   job;

  cmeg_job_t   mem_r [0:1];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr, rd;

  always_comb begin
    p   = {1'b0, tile_res} + 9'd1;
    c   = {tile_res, 2'b00} + 10'd2;
    nn  = {1'b0, in_element_number};
    lim = '0;
    job.mode    = in_mode;
    job.tri_sel = in_want_triangle;
    job.num     = in_element_number;
    job.dvd     = in_element_number;
    job.dvs     = 10'd1;
    unique case (in_mode)
      MESH_TILE: begin
        if (!in_want_triangle) begin
          lim     = {9'd0, p} * {9'd0, p};
          job.dvs = {1'b0, p};
        end else begin
          lim     = {1'b0, {8'd0, tile_res} * {8'd0, tile_res}, 1'b0};
          job.dvd = {1'b0, in_element_number[16:1]};
          job.dvs = {2'b00, tile_res};
        end
      end
      MESH_FILLER: begin
        if (!in_want_triangle) begin
          lim     = {6'd0, p, 3'b000};
          job.dvs = {p, 1'b0};
        end else begin
          lim     = {7'd0, tile_res, 3'b000};
          job.dvd = {1'b0, in_element_number[16:1]};
          job.dvs = {2'b00, tile_res};
        end
      end
      MESH_TRIM: lim = in_want_triangle ? {6'd0, c, 2'b00} - 18'd2 : {6'd0, c, 2'b00} + 18'd2;
      MESH_CROSS: lim = in_want_triangle ? {7'd0, tile_res, 3'b000} + 18'd2 : {6'd0, p, 3'b000};
      MESH_SEAM: begin
        if (!in_want_triangle) begin
          lim     = {6'd0, c, 2'b00};
          job.dvs = c;
        end else begin
          lim = {7'd0, c, 1'b0};
        end
      end
      default: lim = '0;
    endcase
    job.ok = nn < lim;
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rp_r];
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, wr} - {1'b0, rd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= job;
    end
  end

  `CMEG_ASSERT(a_q_cnt_max, cnt_r != 2'd3, "front queue overflow")
  `CMEG_ASSERT(a_q_cnt_step, (wr && !rd) |=> (cnt_r == $past(cnt_r) + 2'd1), "queue count")
  `CMEG_ASSERT(a_q_ptr_gap, (cnt_r == 2'd1) |-> (wp_r != rp_r), "queue pointer mismatch")

endmodule

`default_nettype wire

// ----- rtl/core/cmeg_back.sv -----
// Back end: pipelined restoring divider, element assembly and result queue.
// Depends on cmeg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cmeg_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [7:0]            tile_res,
  input  wire                  q_valid,
  output logic                 q_pop,
  input  cmeg_pkg::cmeg_job_t  q_job,
  output logic                 empty,
  input  wire                  pop,
  output logic                 out_element_valid,
  output logic signed [11:0]   out_coord_x_half,
  output logic signed [11:0]   out_coord_z_half,
  output logic [15:0]          out_corner_first,
  output logic [15:0]          out_corner_second,
  output logic [15:0]          out_corner_third
);
  import cmeg_pkg::*;

  cmeg_div_t  st_r  [0:DIV_STAGES];
  logic       vld_r [0:DIV_STAGES];
  logic       adv;

  cmeg_res_t  omem_r [0:1];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       owr, ord;
  cmeg_res_t  res, ohead;

  cmeg_div_t        f;
  logic [16:0]      qq;
  logic [9:0]       rr;
  logic             s;
  logic [8:0]       p;
  logic [9:0]       c;
  logic signed [15:0] ts, cs, ss, ix, xv, zv;
  logic [17:0]      n18, b, ia, ib, ic, i2;

  assign adv   = (ocnt_r != 2'd2) || pop;
  assign q_pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
      for (int k = 1; k <= DIV_STAGES; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].job <= q_job;
      st_r[0].rem <= '0;
      st_r[0].quo <= q_job.dvd;
      for (int k = 1; k <= DIV_STAGES; k++) st_r[k] <= cmeg_div_step(st_r[k-1]);
    end
  end

  always_comb begin
    f   = st_r[DIV_STAGES];
    qq  = f.quo;
    rr  = f.rem;
    s   = f.job.num[0];
    p   = {1'b0, tile_res} + 9'd1;
    c   = {tile_res, 2'b00} + 10'd2;
    ts  = {8'd0, tile_res};
    cs  = {6'd0, c};
    ss  = {15'd0, s};
    n18 = {1'b0, f.job.num};
    xv  = '0;
    zv  = '0;
    ia  = '0;
    ib  = '0;
    ic  = '0;
    b   = '0;
    i2  = '0;
    ix  = '0;
    unique case (f.job.mode)
      MESH_TILE: begin
        if (!f.job.tri_sel) begin
          xv = {5'd0, rr, 1'b0};
          zv = 16'({qq[14:0], 1'b0});
        end else begin
          b  = {10'd0, qq[7:0]} * {9'd0, p} + {8'd0, rr};
          ia = b;
          if (!s) begin
            ib = b + {9'd0, p} + 18'd1;
            ic = b + {9'd0, p};
          end else begin
            ib = b + 18'd1;
            ic = b + {9'd0, p} + 18'd1;
          end
        end
      end
      MESH_FILLER: begin
        if (!f.job.tri_sel) begin
          ix = ts + {7'd0, rr[9:1]};
          unique case (qq[1:0])
            2'd0: begin xv = 16'((ix + 16'sd1) * 2); zv = 16'(ss * 2); end
            2'd1: begin xv = 16'((16'sd1 - ss) * 2); zv = 16'((ix + 16'sd1) * 2); end
            2'd2: begin xv = 16'(-(ix * 2)); zv = 16'((16'sd1 - ss) * 2); end
            default: begin xv = 16'(ss * 2); zv = 16'(-(ix * 2)); end
          endcase
        end else begin
          b = 18'({(18'(qq) + {2'd0, f.job.num[16:1]}), 1'b0});
          if (!qq[0]) begin
            if (!s) begin ia = b + 18'd1; ib = b; ic = b + 18'd3; end
            else begin ia = b; ib = b + 18'd2; ic = b + 18'd3; end
          end else begin
            if (!s) begin ia = b + 18'd1; ib = b; ic = b + 18'd2; end
            else begin ia = b + 18'd1; ib = b + 18'd2; ic = b + 18'd3; end
          end
        end
      end
      MESH_TRIM: begin
        if (!f.job.tri_sel) begin
          if (n18 < {7'd0, c + 10'd1, 1'b0}) begin
            ix = 16'(n18[17:1]);
            xv = 16'(ss * 2 - (cs + 16'sd1));
            zv = 16'((cs - ix) * 2 - (cs + 16'sd1));
          end else begin
            ix = 16'((n18 - {7'd0, c + 10'd1, 1'b0}) >> 1);
            xv = 16'((ix + 16'sd1) * 2 - (cs + 16'sd1));
            zv = 16'(ss * 2 - (cs + 16'sd1));
          end
        end else begin
          if (n18 < {7'd0, c, 1'b0}) begin
            b  = '0;
            i2 = {n18[17:1], 1'b0};
          end else begin
            b  = {7'd0, c + 10'd1, 1'b0};
            i2 = 18'({((n18 - {7'd0, c, 1'b0}) >> 1), 1'b0});
          end
          if (!s) begin ia = b + i2 + 18'd1; ib = b + i2; ic = b + i2 + 18'd2; end
          else begin ia = b + i2 + 18'd3; ib = b + i2 + 18'd1; ic = b + i2 + 18'd2; end
        end
      end
      MESH_CROSS: begin
        if (!f.job.tri_sel) begin
          if (n18 < {7'd0, p, 2'b00}) begin
            xv = 16'((16'(n18[17:1]) - ts) * 2);
            zv = 16'(ss * 2);
          end else begin
            xv = 16'(ss * 2);
            zv = 16'((16'((n18 - {7'd0, p, 2'b00}) >> 1) - ts) * 2);
          end
        end else begin
          if (n18 < {8'd0, tile_res, 2'b00} + 18'd2) begin
            b = {n18[17:1], 1'b0};
            if (!s) begin ia = b + 18'd1; ib = b; ic = b + 18'd3; end
            else begin ia = b; ib = b + 18'd2; ic = b + 18'd3; end
          end else begin
            i2 = (n18 - ({8'd0, tile_res, 2'b00} + 18'd2)) >> 1;
            if (i2 >= {10'd0, tile_res}) i2 = i2 + 18'd1;
            b = {7'd0, p, 2'b00} + 18'({i2, 1'b0});
            if (!s) begin ia = b + 18'd1; ib = b + 18'd3; ic = b; end
            else begin ia = b; ib = b + 18'd3; ic = b + 18'd2; end
          end
        end
      end
      MESH_SEAM: begin
        if (!f.job.tri_sel) begin
          ix = {6'd0, rr};
          unique case (qq[1:0])
            2'd0: begin xv = 16'(ix * 2); zv = '0; end
            2'd1: begin xv = 16'(cs * 2); zv = 16'(ix * 2); end
            2'd2: begin xv = 16'((cs - ix) * 2); zv = 16'(cs * 2); end
            default: begin xv = '0; zv = 16'((cs - ix) * 2); end
          endcase
        end else begin
          ia = 18'({n18, 1'b0}) + 18'd1;
          ib = 18'({n18, 1'b0});
          ic = (n18 == {7'd0, c, 1'b0} - 18'd1) ? 18'd0 : 18'({n18, 1'b0}) + 18'd2;
        end
      end
      default: ;
    endcase
    res.ok = f.job.ok;
    res.x  = f.job.ok ? xv[11:0] : '0;
    res.z  = f.job.ok ? zv[11:0] : '0;
    res.ca = f.job.ok ? ia[15:0] : '0;
    res.cb = f.job.ok ? ib[15:0] : '0;
    res.cc = f.job.ok ? ic[15:0] : '0;
  end

  assign owr      = adv && vld_r[DIV_STAGES];
  assign ord      = pop && !empty;
  assign empty    = (ocnt_r == 2'd0);
  assign ocnt_nxt = 2'(ocnt_r + {1'b0, owr} - {1'b0, ord});
  assign ohead    = omem_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (owr) owp_r <= ~owp_r;
      if (ord) orp_r <= ~orp_r;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (owr) omem_r[owp_r] <= res;
  end

  assign out_element_valid = ohead.ok;
  assign out_coord_x_half  = ohead.x;
  assign out_coord_z_half  = ohead.z;
  assign out_corner_first  = ohead.ca;
  assign out_corner_second = ohead.cb;
  assign out_corner_third  = ohead.cc;

  `CMEG_ASSERT(a_out_cnt_max, ocnt_r != 2'd3, "result queue overflow")
  `CMEG_ASSERT(a_stall_hold, !adv |=> $stable(vld_r[DIV_STAGES]), "pipeline moved while stalled")
  `CMEG_ASSERT(a_bad_zero, (owr && !res.ok) |-> (res.ca == 16'd0 && res.x == 12'sd0),
    "invalid result not cleared")

endmodule

`default_nettype wire

// ----- rtl/core/clipmap_mesh_element_generator.sv -----
// Top level of the clipmap mesh element generator: tile resolution register,
// front end and back end. Depends on cmeg_pkg, cmeg_front and cmeg_back.
//
//  channel  | ports                                  | transaction when
//  ---------+----------------------------------------+---------------------
//  input    | push, full, in_mode/want_triangle/...  | push && !full
//  result   | empty, pop, out_element_valid/...      | pop && !empty
//  config   | cfg_we, cfg_wdata                      | cfg_we
//
// One transaction per cycle sustained while the result queue is not stalled;
// a result passes through the front queue, the 17-stage restoring divider
// by T, P, 2P, C or 1 and the result queue.
// Reset is synchronous; tile resolution resets to 32.
// A stalled result queue stalls the whole back pipeline; the 2-entry front
// queue absorbs input until it fills.
`timescale 1ns / 1ps
`default_nettype none

module clipmap_mesh_element_generator (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [7:0]          cfg_wdata,
  input  wire                push,
  output logic               full,
  input  wire [2:0]          in_mode,
  input  wire                in_want_triangle,
  input  wire [16:0]         in_element_number,
  output logic               empty,
  input  wire                pop,
  output logic               out_element_valid,
  output logic signed [11:0] out_coord_x_half,
  output logic signed [11:0] out_coord_z_half,
  output logic [15:0]        out_corner_first,
  output logic [15:0]        out_corner_second,
  output logic [15:0]        out_corner_third
);
  import cmeg_pkg::*;

  logic [7:0] tres_r, tres_nxt;
  logic       q_valid, q_pop;
  cmeg_job_t  q_job;

  assign tres_nxt = cfg_we ? cfg_wdata : tres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tres_r <= 8'(T_RESET);
    else        tres_r <= tres_nxt;
  end

  cmeg_front u_front (
    .clk, .rst_n,
    .tile_res(tres_r),
    .push, .full,
    .in_mode, .in_want_triangle, .in_element_number,
    .q_valid, .q_pop, .q_job
  );

  cmeg_back u_back (
    .clk, .rst_n,
    .tile_res(tres_r),
    .q_valid, .q_pop, .q_job,
    .empty, .pop,
    .out_element_valid, .out_coord_x_half, .out_coord_z_half,
    .out_corner_first, .out_corner_second, .out_corner_third
  );

endmodule

`default_nettype wire

// ----- tb/clipmap_mesh_checker.sv -----
// Checker for the clipmap mesh element generator: tracks the tile resolution,
// predicts each element from accepted input transactions and compares results.
// Depends on cmeg_pkg.
`timescale 1ns / 1ps

module clipmap_mesh_checker
  import cmeg_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [7:0]   cfg_wdata,
  input  wire         push,
  input  wire         full,
  input  wire [2:0]   in_mode,
  input  wire         in_want_triangle,
  input  wire [16:0]  in_element_number,
  input  wire         empty,
  input  wire         pop,
  input  wire         out_element_valid,
  input  wire [11:0]  out_coord_x_half,
  input  wire [11:0]  out_coord_z_half,
  input  wire [15:0]  out_corner_first,
  input  wire [15:0]  out_corner_second,
  input  wire [15:0]  out_corner_third,
  output int          errors,
  output int          pending
);

  cmeg_res_t  expected_elems[$];
  int         tile_res;

  function automatic cmeg_res_t mesh_element(logic [2:0] m, logic tr, int n, int t);
    cmeg_res_t r;
    int p, c, s, q, x, y, arm, i, fr, b, st, base, vs;
    int rx, rz, ra, rb, rc;
    bit ok;
    p = t + 1;
    c = 4 * t + 2;
    s = n & 1;
    ok = 0;
    rx = 0; rz = 0; ra = 0; rb = 0; rc = 0;
    case (m)
      MESH_TILE: begin
        if (!tr) begin
          if (n < p * p) begin
            ok = 1; rx = 2 * (n % p); rz = 2 * (n / p);
          end
        end else if (n < 2 * t * t) begin
          ok = 1; q = n / 2; y = q / t; x = q % t;
          ra = y * p + x;
          if (s == 0) begin
            rb = (y + 1) * p + x + 1; rc = (y + 1) * p + x;
          end else begin
            rb = y * p + x + 1; rc = (y + 1) * p + x + 1;
          end
        end
      end
      MESH_FILLER: begin
        if (!tr) begin
          if (n < 8 * p) begin
            ok = 1; arm = n / (2 * p); i = (n % (2 * p)) / 2; fr = t + i;
            case (arm)
              0: begin rx = 2 * (fr + 1); rz = 2 * s; end
              1: begin rx = 2 * (1 - s); rz = 2 * (fr + 1); end
              2: begin rx = -2 * fr; rz = 2 * (1 - s); end
              default: begin rx = 2 * s; rz = -2 * fr; end
            endcase
          end
        end else if (n < 8 * t) begin
          ok = 1; q = n / 2; arm = q / t; b = (arm + q) * 2;
          if ((arm & 1) == 0) begin
            if (s == 0) begin ra = b + 1; rb = b; rc = b + 3; end
            else begin ra = b; rb = b + 2; rc = b + 3; end
          end else begin
            if (s == 0) begin ra = b + 1; rb = b; rc = b + 2; end
            else begin ra = b + 1; rb = b + 2; rc = b + 3; end
          end
        end
      end
      MESH_TRIM: begin
        st = 2 * (c + 1);
        if (!tr) begin
          if (n < 4 * c + 2) begin
            ok = 1;
            if (n < st) begin
              i = n / 2; rx = 2 * s - (c + 1); rz = 2 * (c - i) - (c + 1);
            end else begin
              i = (n - st) / 2; rx = 2 * (i + 1) - (c + 1); rz = 2 * s - (c + 1);
            end
          end
        end else if (n < 4 * c - 2) begin
          ok = 1;
          if (n < 2 * c) begin
            base = 0; i = n / 2;
          end else begin
            base = st; i = (n - 2 * c) / 2;
          end
          if (s == 0) begin
            ra = base + 2 * i + 1; rb = base + 2 * i; rc = base + 2 * i + 2;
          end else begin
            ra = base + 2 * i + 3; rb = base + 2 * i + 1; rc = base + 2 * i + 2;
          end
        end
      end
      MESH_CROSS: begin
        vs = 4 * p;
        if (!tr) begin
          if (n < 8 * p) begin
            ok = 1;
            if (n < vs) begin
              rx = 2 * (n / 2 - t); rz = 2 * s;
            end else begin
              rx = 2 * s; rz = 2 * ((n - vs) / 2 - t);
            end
          end
        end else if (n < 8 * t + 2) begin
          ok = 1;
          if (n < 4 * t + 2) begin
            b = (n / 2) * 2;
            if (s == 0) begin ra = b + 1; rb = b; rc = b + 3; end
            else begin ra = b; rb = b + 2; rc = b + 3; end
          end else begin
            // vertical strip has no quad at the center
            q = (n - (4 * t + 2)) / 2;
            i = (q < t) ? q : q + 1;
            b = vs + 2 * i;
            if (s == 0) begin ra = b + 1; rb = b + 3; rc = b; end
            else begin ra = b; rb = b + 3; rc = b + 2; end
          end
        end
      end
      MESH_SEAM: begin
        if (!tr) begin
          if (n < 4 * c) begin
            ok = 1; arm = n / c; i = n % c;
            case (arm)
              0: begin rx = 2 * i; rz = 0; end
              1: begin rx = 2 * c; rz = 2 * i; end
              2: begin rx = 2 * (c - i); rz = 2 * c; end
              default: begin rx = 0; rz = 2 * (c - i); end
            endcase
          end
        end else if (n < 2 * c) begin
          ok = 1; ra = 2 * n + 1; rb = 2 * n;
          rc = (n == 2 * c - 1) ? 0 : 2 * n + 2;
        end
      end
      default: ok = 0;
    endcase
    if (!ok) begin
      rx = 0; rz = 0; ra = 0; rb = 0; rc = 0;
    end
    r.ok = ok;
    r.x  = rx[11:0];
    r.z  = rz[11:0];
    r.ca = ra[15:0];
    r.cb = rb[15:0];
    r.cc = rc[15:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    tile_res = T_RESET;
  end

  always @(posedge clk) begin
    cmeg_res_t want;
    if (!rst_n) begin
      tile_res <= T_RESET;
    end else begin
      if (cfg_we)
        tile_res <= cfg_wdata;
      if (push && !full)
        expected_elems.push_back(mesh_element(in_mode, in_want_triangle,
                                              in_element_number, tile_res));
      if (pop && !empty) begin
        if (expected_elems.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t: unexpected result transaction", $realtime);
        end else begin
          want = expected_elems.pop_front();
          if (want.ok !== out_element_valid || want.x !== out_coord_x_half ||
              want.z !== out_coord_z_half || want.ca !== out_corner_first ||
              want.cb !== out_corner_second || want.cc !== out_corner_third) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("%0t: mismatch exp v=%0d x=%0d z=%0d c=%0d,%0d,%0d got v=%0d x=%0d z=%0d c=%0d,%0d,%0d",
                       $realtime, want.ok, $signed(want.x), $signed(want.z),
                       want.ca, want.cb, want.cc, out_element_valid,
                       $signed(out_coord_x_half), $signed(out_coord_z_half),
                       out_corner_first, out_corner_second, out_corner_third);
          end
        end
      end
      pending = expected_elems.size();
    end
  end

endmodule

// ----- tb/tb_clipmap_mesh_element_generator.sv -----
// Testbench top for the clipmap mesh element generator: clock, reset, stimulus
// over several tile resolutions, receiver stalls and the verdict.
// Depends on cmeg_pkg, clipmap_mesh_element_generator and clipmap_mesh_checker.
`timescale 1ns / 1ps

module tb_clipmap_mesh_element_generator;
  import cmeg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 30;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [7:0]  cfg_wdata = 0;
  logic        push = 0;
  logic        full;
  logic [2:0]  in_mode = 0;
  logic        in_want_triangle = 0;
  logic [16:0] in_element_number = 0;
  logic        empty;
  logic        pop = 0;
  logic        out_element_valid;
  logic [11:0] out_coord_x_half;
  logic [11:0] out_coord_z_half;
  logic [15:0] out_corner_first;
  logic [15:0] out_corner_second;
  logic [15:0] out_corner_third;
  int          errors;
  int          pending;
  int          stall_cycles = 0;
  bit          hold_off_req = 0;
  bit          steady = 0;
  int          cur_res = T_RESET;

  always #10 clk = ~clk;

  clipmap_mesh_element_generator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_mode(in_mode),
    .in_want_triangle(in_want_triangle), .in_element_number(in_element_number),
    .empty(empty), .pop(pop), .out_element_valid(out_element_valid),
    .out_coord_x_half(out_coord_x_half), .out_coord_z_half(out_coord_z_half),
    .out_corner_first(out_corner_first), .out_corner_second(out_corner_second),
    .out_corner_third(out_corner_third)
  );

  clipmap_mesh_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_mode(in_mode),
    .in_want_triangle(in_want_triangle), .in_element_number(in_element_number),
    .empty(empty), .pop(pop), .out_element_valid(out_element_valid),
    .out_coord_x_half(out_coord_x_half), .out_coord_z_half(out_coord_z_half),
    .out_corner_first(out_corner_first), .out_corner_second(out_corner_second),
    .out_corner_third(out_corner_third), .errors(errors), .pending(pending)
  );

  function automatic int element_count(logic [2:0] m, logic tr, int t);
    int c;
    c = 4 * t + 2;
    case (m)
      MESH_TILE:   return tr ? 2 * t * t : (t + 1) * (t + 1);
      MESH_FILLER: return tr ? 8 * t : 8 * (t + 1);
      MESH_TRIM:   return tr ? 4 * c - 2 : 4 * c + 2;
      MESH_CROSS:  return tr ? 8 * t + 2 : 8 * (t + 1);
      MESH_SEAM:   return tr ? 2 * c : 4 * c;
      default:     return 0;
    endcase
  endfunction

  task automatic send_element(logic [2:0] m, logic tr, int n);
    push              <= 1;
    in_mode           <= m;
    in_want_triangle  <= tr;
    in_element_number <= n[16:0];
    @(posedge clk);
    while (full) @(posedge clk);
    if (!steady && $urandom_range(99) < 28) begin
      push <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_resolution(int v);
    cfg_we    <= 1;
    cfg_wdata <= v[7:0];
    cur_res = v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_set;
    int cnt;
    for (int m = 0; m <= MESH_SEAM; m++)
      for (int tr = 0; tr < 2; tr++) begin
        cnt = element_count(m[2:0], tr[0], cur_res);
        send_element(m[2:0], tr[0], 0);
        if (cnt > 1) send_element(m[2:0], tr[0], cnt - 1);
        if (cnt > 2) send_element(m[2:0], tr[0], cnt - 2);
        send_element(m[2:0], tr[0], cnt);
      end
    send_element(MESH_SEAM + 3'd1, 1'b0, 3);
    send_element(3'd7, 1'b1, 131071);
    send_element(MESH_TILE, 1'b1, 131071);
  endtask

  task automatic random_items(int count);
    logic [2:0] m;
    logic       tr;
    int         cnt;
    int         n;
    for (int k = 0; k < count; k++) begin
      m  = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
      tr = 1'($urandom_range(1));
      cnt = element_count(m, tr, cur_res);
      if (cnt > 0 && $urandom_range(99) < 85)
        n = $urandom_range(cnt - 1);
      else
        n = $urandom_range(131071);
      send_element(m, tr, n);
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        pop <= 0;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end else begin
        pop <= steady ? 1'b1 : ($urandom_range(99) >= 28);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int res_list[6];
    res_list = '{T_RESET, 1, 255, 0, 2, 0};
    res_list[5] = $urandom_range(254, 3);
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) write_resolution(res_list[ph]);
      directed_set();
      if (ph == 1) begin
        hold_off_req = 1;
        random_items(60);
      end
      steady = (ph == 2);
      random_items(150);
      steady = 0;
      drain();
    end
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
